// ===== rtl/adrm_pkg.sv =====
// ----------------------------------------------------------------------------
// adrm_pkg
// Shared types, constants and the name pattern compare for the advertising
// report matcher.
// ----------------------------------------------------------------------------
package adrm_pkg;

  localparam int NAME_BUFFER_BYTES_DEF = 32;
  localparam int WIN_DEPTH = 6;
  localparam int PAT_COUNT = 8;
  localparam int PAT_MAX = 7;

  // Parse phases
  localparam logic [1:0] PH_LEN     = 2'd0;
  localparam logic [1:0] PH_TYPE    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_STOP    = 2'd3;

  // Structure types
  localparam logic [7:0] AD_UUID16_PART  = 8'h02;
  localparam logic [7:0] AD_UUID16_FULL  = 8'h03;
  localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
  localparam logic [7:0] AD_NAME_FULL    = 8'h09;

  // Service UUIDs of interest
  localparam logic [15:0] UUID_A = 16'hFFE0;
  localparam logic [15:0] UUID_B = 16'hFFF0;
  localparam logic [15:0] UUID_C = 16'h18F0;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_MAX] = '{
    '{"O", "B", "D", "I", "I", 8'h00, 8'h00},
    '{"O", "B", "D", "2", 8'h00, 8'h00, 8'h00},
    '{"V", "L", "I", "N", "K", 8'h00, 8'h00},
    '{"V", "G", "A", "T", "E", 8'h00, 8'h00},
    '{"V", "E", "E", "P", "E", "A", "K"},
    '{"I", "C", "A", "R", 8'h00, 8'h00, 8'h00},
    '{"E", "L", "M", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "T", "O", "B", "D", 8'h00, 8'h00}
  };
  localparam int PAT_LEN [PAT_COUNT] = '{5, 4, 5, 5, 7, 4, 3, 5};

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      c = b - 8'h20;
    end
    return c;
  endfunction

  // True when c, preceded by the window (newest first), completes a pattern.
  function automatic logic name_hit(input logic [7:0] c, input win_t w);
    logic hit;
    logic ok;
    hit = 1'b0;
    for (int p = 0; p < PAT_COUNT; p++) begin
      ok = (PAT_TEXT[p][PAT_LEN[p]-1] == c);
      for (int j = 0; j < WIN_DEPTH; j++) begin
        if (j + 2 <= PAT_LEN[p]) begin
          if (PAT_TEXT[p][PAT_LEN[p]-2-j] != w[j]) begin
            ok = 1'b0;
          end
        end
      end
      hit = hit | ok;
    end
    return hit;
  endfunction

endpackage

// ===== rtl/adrm_char_cell.sv =====
// ----------------------------------------------------------------------------
// adrm_char_cell
// One cell of the name character window: holds one uppercased byte and takes
// its neighbour's byte on every shift.
// ----------------------------------------------------------------------------
module adrm_char_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  adrm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          d_in,
  output logic [7:0]          q
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.clear) begin
      q_nxt = 8'h00;
    end else if (ctrl.shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 8'h00;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/ble_adv_report_matcher_top.sv =====
// ----------------------------------------------------------------------------
// ble_adv_report_matcher_top
// Walks the length/type/payload structures of an advertising report, one
// byte per request, and flags reports that name a known adapter or list one
// of its service UUIDs.
// ----------------------------------------------------------------------------
// Throughput: one report byte per cycle, but a final byte waits while a flag
// is held at the output; the parser and the six-cell character chain update in the cycle a byte is accepted.
// The flag is valid in the cycle after the last byte is accepted.
// A non-final byte is taken even while a flag waits at the output.
// Reset (rst_n low, synchronous) returns the parser to the length byte and
// clears the character chain and the output.
module ble_adv_report_matcher_top #(
  parameter int NAME_BUFFER_BYTES = adrm_pkg::NAME_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_adv_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_looks_like_adapter
);

  localparam logic [8:0] NAME_LIMIT = 9'(NAME_BUFFER_BYTES);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] kind_r, kind_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] uuid_low_r, uuid_low_nxt;
  logic       name_ended_r, name_ended_nxt;
  logic       pending_r, pending_nxt;
  logic       report_hit_r, report_hit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_flag_r, out_flag_nxt;

  logic                 accept;
  logic [7:0]           upper_c;
  logic                 is_name;
  logic                 is_uuid;
  logic                 name_room;
  logic                 done;
  logic                 report_flag;
  logic [7:0]           left_dec;
  adrm_pkg::cell_ctrl_t cell_ctrl;
  adrm_pkg::win_t       win;

  // A final byte must wait for the output register; others need not.
  assign in_ready = !out_valid_r || out_ready || !in_last_byte;
  assign accept   = in_valid && in_ready;

  assign upper_c   = adrm_pkg::to_upper(in_adv_byte);
  assign is_name   = (kind_r == adrm_pkg::AD_NAME_SHORT) ||
                     (kind_r == adrm_pkg::AD_NAME_FULL);
  assign is_uuid   = (kind_r == adrm_pkg::AD_UUID16_PART) ||
                     (kind_r == adrm_pkg::AD_UUID16_FULL);
  assign name_room = ({1'b0, count_r} + 9'd1) < NAME_LIMIT;
  assign left_dec  = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    uuid_low_nxt   = uuid_low_r;
    name_ended_nxt = name_ended_r;
    pending_nxt    = pending_r;
    report_hit_nxt = report_hit_r;
    cell_ctrl      = '{clear: 1'b0, shift: 1'b0};
    done           = 1'b0;
    report_flag    = report_hit_r;

    if (accept) begin
      unique case (phase_r)
        adrm_pkg::PH_LEN: begin
          if (in_adv_byte == 8'h00) begin
            phase_nxt = adrm_pkg::PH_STOP;
          end else begin
            bytes_left_nxt = in_adv_byte;
            phase_nxt      = adrm_pkg::PH_TYPE;
          end
        end
        adrm_pkg::PH_TYPE: begin
          kind_nxt        = in_adv_byte;
          count_nxt       = 8'h00;
          uuid_low_nxt    = 8'h00;
          name_ended_nxt  = 1'b0;
          pending_nxt     = 1'b0;
          cell_ctrl.clear = 1'b1;
          bytes_left_nxt  = left_dec;
          if (left_dec == 8'h00) begin
            done = 1'b1;
          end else begin
            phase_nxt = adrm_pkg::PH_PAYLOAD;
          end
        end
        adrm_pkg::PH_PAYLOAD: begin
          if (is_name) begin
            if (!name_ended_r && name_room) begin
              if (in_adv_byte == 8'h00) begin
                name_ended_nxt = 1'b1;
              end else begin
                cell_ctrl.shift = 1'b1;
                if (adrm_pkg::name_hit(upper_c, win)) begin
                  pending_nxt = 1'b1;
                end
              end
            end
          end else if (is_uuid) begin
            if (!count_r[0]) begin
              uuid_low_nxt = in_adv_byte;
            end else if ({in_adv_byte, uuid_low_r} == adrm_pkg::UUID_A ||
                         {in_adv_byte, uuid_low_r} == adrm_pkg::UUID_B ||
                         {in_adv_byte, uuid_low_r} == adrm_pkg::UUID_C) begin
              pending_nxt = 1'b1;
            end
          end
          count_nxt      = count_r + 8'd1;
          bytes_left_nxt = left_dec;
          if (left_dec == 8'h00) begin
            done = 1'b1;
          end
        end
        adrm_pkg::PH_STOP: begin
        end
        default: begin
        end
      endcase

      if (done) begin
        report_hit_nxt = report_hit_r | pending_nxt;
        pending_nxt    = 1'b0;
        phase_nxt      = adrm_pkg::PH_LEN;
      end

      // The flag includes a structure that closes on this very byte.
      report_flag = report_hit_nxt;

      // End of report: the parser state and the character chain return to their reset values.
      if (in_last_byte) begin
        phase_nxt       = adrm_pkg::PH_LEN;
        bytes_left_nxt  = 8'h00;
        kind_nxt        = 8'h00;
        count_nxt       = 8'h00;
        uuid_low_nxt    = 8'h00;
        name_ended_nxt  = 1'b0;
        pending_nxt     = 1'b0;
        report_hit_nxt  = 1'b0;
        cell_ctrl.clear = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    if (accept && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_flag_nxt  = report_flag;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Character window: a chain of cells, newest byte in cell 0.
  for (genvar i = 0; i < adrm_pkg::WIN_DEPTH; i++) begin : g_cell
    logic [7:0] d_in;
    if (i == 0) begin : g_head
      assign d_in = upper_c;
    end else begin : g_link
      assign d_in = win[i-1];
    end
    adrm_char_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (cell_ctrl),
      .d_in  (d_in),
      .q     (win[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= adrm_pkg::PH_LEN;
      bytes_left_r <= 8'h00;
      kind_r       <= 8'h00;
      count_r      <= 8'h00;
      uuid_low_r   <= 8'h00;
      name_ended_r <= 1'b0;
      pending_r    <= 1'b0;
      report_hit_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_flag_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      kind_r       <= kind_nxt;
      count_r      <= count_nxt;
      uuid_low_r   <= uuid_low_nxt;
      name_ended_r <= name_ended_nxt;
      pending_r    <= pending_nxt;
      report_hit_r <= report_hit_nxt;
      out_valid_r  <= out_valid_nxt;
      out_flag_r   <= out_flag_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_looks_like_adapter = out_flag_r;

  // A final byte always leaves a flag at the output in the next cycle.
  a_flag_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> out_valid_r)
    else $error("no flag after the last byte of a report");

  // The end of a report returns the parser to the length byte.
  a_parser_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (phase_r == adrm_pkg::PH_LEN && !report_hit_r &&
                                  win == '0))
    else $error("parser state not cleared at the end of a report");

  // Once stopped by a zero length, only the report end restarts parsing.
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == adrm_pkg::PH_STOP && !(accept && in_last_byte))
      |=> (phase_r == adrm_pkg::PH_STOP))
    else $error("parser left the stopped phase inside a report");

  // A match in progress belongs to a structure whose payload is being read.
  a_pending_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (phase_r == adrm_pkg::PH_PAYLOAD))
    else $error("pending match outside a structure payload");

endmodule
